// ===== rtl/ifa_pkg.sv =====
package ifa_pkg;

	// field widths fixed by the header format
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned HDR_B_W   = 6;
	localparam int unsigned OFFSET_W  = 13;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned DELIVER_W = 17;

	// stream packing
	localparam int unsigned S_TDATA_W = 104;
	localparam int unsigned M_TDATA_W = 40;
	localparam int unsigned M_TUSER_W = 2;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FLOW_SRC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_DST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAG  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd3;

	localparam logic [LEN_W-1:0] MIN_FRAG_RESET = 16'd8;
	localparam logic [LEN_W-1:0] TIMEOUT_RESET  = 16'd30;

	// header constants
	localparam logic [3:0]         IPV4_VERSION     = 4'd4;
	localparam logic [HDR_B_W-1:0] MIN_HEADER_BYTES = 6'd20;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_IPV4     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_HDR_LEN  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_DATA      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ADDR_MISS    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_FRAGMENT = 3'd5;
	localparam logic [STATUS_W-1:0] ST_TOO_SHORT    = 3'd6;
	localparam logic [STATUS_W-1:0] ST_OVERRUN      = 3'd7;

	// flush reasons
	localparam logic REASON_DONE    = 1'b0;
	localparam logic REASON_TIMEOUT = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] flow_source_addr;
		logic [ADDR_W-1:0] flow_dest_addr;
		logic [LEN_W-1:0]  min_fragment_bytes;
		logic [LEN_W-1:0]  timeout_seconds;
	} cfg_t;

	typedef struct packed {
		logic                kind;
		logic [3:0]          version;
		logic [3:0]          header_words;
		logic [LEN_W-1:0]    total_length;
		logic [ADDR_W-1:0]   src_addr;
		logic [ADDR_W-1:0]   dst_addr;
		logic                more_fragments;
		logic                dont_fragment;
		logic [OFFSET_W-1:0] offset_units;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0]   end_bytes;
		logic [LEN_W-1:0]   received_bytes;
		logic               final_seen;
		logic [HDR_B_W-1:0] final_header_bytes;
		logic [LEN_W-1:0]   idle_ticks;
	} flow_t;

	typedef struct packed {
		logic                 valid;
		logic [STATUS_W-1:0]  status;
		logic                 flushed;
		logic                 flush_reason;
		logic [DELIVER_W-1:0] delivered_length;
		logic [LEN_W-1:0]     highest_end;
	} result_t;

endpackage

// ===== rtl/ifa_cfg_regs.sv =====
module ifa_cfg_regs
	import ifa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register file, one write per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flow_source_addr   <= '0;
			cfg_q.flow_dest_addr     <= '0;
			cfg_q.min_fragment_bytes <= MIN_FRAG_RESET;
			cfg_q.timeout_seconds    <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FLOW_SRC: cfg_q.flow_source_addr   <= cfg_data;
				REG_FLOW_DST: cfg_q.flow_dest_addr     <= cfg_data;
				REG_MIN_FRAG: cfg_q.min_fragment_bytes <= cfg_data[LEN_W-1:0];
				REG_TIMEOUT:  cfg_q.timeout_seconds    <= cfg_data[LEN_W-1:0];
				default:      cfg_q                    <= cfg_q;
			endcase
		end
	end

endmodule

// ===== rtl/ifa_check.sv =====
module ifa_check
	import ifa_pkg::*;
#(
	parameter int unsigned MAX_DATAGRAM_BYTES = 65535
) (
	input  item_t   item,
	input  cfg_t    cfg,
	input  flow_t   flow,
	output flow_t   flow_next,
	output result_t res
);

	localparam logic [LEN_W:0] MAX_LIMIT = (LEN_W+1)'(MAX_DATAGRAM_BYTES);

	logic [HDR_B_W-1:0] hdr_bytes;
	logic [LEN_W-1:0]   payload_len;
	logic [LEN_W-1:0]   offset_bytes;
	logic [LEN_W:0]     recv_sum;
	logic [LEN_W:0]     fin_sum;
	logic [STATUS_W-1:0] status;
	logic [LEN_W-1:0]   new_end;
	logic [LEN_W-1:0]   new_recv;
	logic               new_final;
	logic [HDR_B_W-1:0] new_hdr;
	logic [LEN_W-1:0]   idle_inc;

	// header arithmetic
	assign hdr_bytes    = {item.header_words, 2'b00};
	assign payload_len  = item.total_length - LEN_W'(hdr_bytes);
	assign offset_bytes = {item.offset_units, 3'b000};
	assign recv_sum     = {1'b0, flow.received_bytes} + {1'b0, payload_len};
	assign fin_sum      = {1'b0, offset_bytes} + {1'b0, payload_len};

	// checks in priority order
	always_comb begin
		if (item.version != IPV4_VERSION)
			status = ST_NOT_IPV4;
		else if (hdr_bytes < MIN_HEADER_BYTES)
			status = ST_BAD_HDR_LEN;
		else if (item.total_length <= LEN_W'(hdr_bytes))
			status = ST_NO_DATA;
		else if (item.src_addr != cfg.flow_source_addr ||
				item.dst_addr != cfg.flow_dest_addr)
			status = ST_ADDR_MISS;
		else if ((!item.more_fragments && item.offset_units == '0) || item.dont_fragment)
			status = ST_NOT_FRAGMENT;
		else if (item.more_fragments && payload_len < cfg.min_fragment_bytes)
			status = ST_TOO_SHORT;
		else if (recv_sum > MAX_LIMIT || fin_sum > MAX_LIMIT)
			status = ST_OVERRUN;
		else
			status = ST_OK;
	end

	// flow after an accepted fragment
	assign new_end   = (flow.end_bytes < fin_sum[LEN_W-1:0]) ? fin_sum[LEN_W-1:0]
		: flow.end_bytes;
	assign new_recv  = recv_sum[LEN_W-1:0];
	assign new_final = flow.final_seen | ~item.more_fragments;
	assign new_hdr   = item.more_fragments ? flow.final_header_bytes : hdr_bytes;

	// saturating idle count
	assign idle_inc = (flow.idle_ticks == '1) ? flow.idle_ticks : flow.idle_ticks + 1'b1;

	// next state and result
	always_comb begin
		flow_next = flow;
		res       = '0;
		if (item.kind) begin
			if (flow.received_bytes != '0) begin
				if (idle_inc > cfg.timeout_seconds) begin
					res.valid            = 1'b1;
					res.status           = ST_OK;
					res.flushed          = 1'b1;
					res.flush_reason     = REASON_TIMEOUT;
					res.delivered_length = {1'b0, flow.received_bytes}
						+ DELIVER_W'(flow.final_header_bytes);
					res.highest_end      = flow.end_bytes;
					flow_next            = '0;
				end else begin
					flow_next.idle_ticks = idle_inc;
				end
			end
		end else if (status != ST_OK) begin
			res.valid       = 1'b1;
			res.status      = status;
			res.highest_end = flow.end_bytes;
		end else if (new_final && new_end == new_recv) begin
			res.valid            = 1'b1;
			res.status           = ST_OK;
			res.flushed          = 1'b1;
			res.flush_reason     = REASON_DONE;
			res.delivered_length = {1'b0, new_recv} + DELIVER_W'(new_hdr);
			res.highest_end      = new_end;
			flow_next            = '0;
		end else begin
			res.valid                    = 1'b1;
			res.status                   = ST_OK;
			res.highest_end              = new_end;
			flow_next.end_bytes          = new_end;
			flow_next.received_bytes     = new_recv;
			flow_next.final_seen         = new_final;
			flow_next.final_header_bytes = new_hdr;
			flow_next.idle_ticks         = '0;
		end
	end

endmodule

// ===== rtl/ipv4_fragment_accounting_core.sv =====
// channel | direction | beat contents
// s_*     | in        | tuser: kind; tdata: fragment header fields
// m_*     | out       | tuser: flushed, flush_reason; tdata: status, lengths
// cfg_*   | in        | register index and write data, always ready
//
// one item per cycle sustained unless m_tready stalls the output: a beat lands in
// the input register, is checked and applied to the flow state combinationally,
// and its result is written to the output register, behind the input register.
// a tick that causes no flush is consumed without a result.
// arst_n clears the flow, both valid flags and the register defaults.
// the input register is released whenever the output register is empty or taken.
module ipv4_fragment_accounting_core
	import ifa_pkg::*;
#(
	parameter int unsigned MAX_DATAGRAM_BYTES = 65535
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [3:0] version, [7:4] header_words, [23:8] total_length, [55:24] src_addr,
	// [87:56] dst_addr, [88] more_fragments, [89] dont_fragment,
	// [102:90] offset_units, [103] zero
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// [0] kind
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] status, [19:3] delivered_length, [35:20] highest_end, [39:36] zero
	output logic [M_TDATA_W-1:0]  m_tdata,
	// [0] flushed, [1] flush_reason
	output logic [M_TUSER_W-1:0]  m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	flow_t   flow_q;
	flow_t   flow_next;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    out_free;
	logic    fire;

	ifa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// unpack the input beat
	always_comb begin
		item_in.kind           = s_tuser;
		item_in.version        = s_tdata[3:0];
		item_in.header_words   = s_tdata[7:4];
		item_in.total_length   = s_tdata[23:8];
		item_in.src_addr       = s_tdata[55:24];
		item_in.dst_addr       = s_tdata[87:56];
		item_in.more_fragments = s_tdata[88];
		item_in.dont_fragment  = s_tdata[89];
		item_in.offset_units   = s_tdata[102:90];
	end

	// handshake
	assign out_free = ~valid_s2 | m_tready;
	assign fire     = valid_s1 & out_free;
	assign s_tready = ~valid_s1 | out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	ifa_check #(
		.MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
	) u_check (
		.item      (item_s1),
		.cfg       (cfg),
		.flow      (flow_q),
		.flow_next (flow_next),
		.res       (res)
	);

	// flow state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_q <= '0;
		end else if (fire) begin
			flow_q <= flow_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire & res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, res_s2.highest_end, res_s2.delivered_length, res_s2.status};
	assign m_tuser  = {res_s2.flush_reason, res_s2.flushed};

endmodule

// ===== rtl/ifa_props.sv =====
module ifa_props
	import ifa_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed under stall");

	// a flush always carries ok status
	a_flush_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[2:0] == ST_OK)
		else $error("flush with error status");

	// timeout reason only on a flush
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("flush reason without flush");

	// no delivered length without a flush
	a_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[19:3] == '0)
		else $error("delivered length without flush");

	// a complete datagram delivers its end plus a full header
	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && !m_tuser[1]
		|-> m_tdata[19:3] >= ({1'b0, m_tdata[35:20]} + 17'd20))
		else $error("complete flush shorter than end plus header");

endmodule

bind ipv4_fragment_accounting_core ifa_props u_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== sim/ifa_flow_checker.sv =====
`timescale 1ns / 1ps

module ifa_flow_checker
	import ifa_pkg::*;
#(
	parameter int unsigned MAX_DATAGRAM_BYTES = 65535
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	input  logic [M_TUSER_W-1:0]  m_tuser,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           errors,
	output int unsigned           pending
);

	cfg_t        flow_regs;
	flow_t       flow;
	result_t     results_due[$];
	int unsigned fail_count = 0;
	int unsigned due_count  = 0;

	assign errors  = fail_count;
	assign pending = due_count;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $realtime, msg);
		fail_count++;
	endtask

	// tick aging, or header checks in priority order, then the flow update and flush decision
	task automatic account_item(input item_t beat);
		int unsigned         hdr_bytes;
		int unsigned         payload;
		int unsigned         offset_bytes;
		int unsigned         frag_end;
		logic [STATUS_W-1:0] status;
		result_t             res;
		res       = '0;
		res.valid = 1'b1;
		if (beat.kind) begin
			// ticks only age a flow that holds data
			if (flow.received_bytes != 0) begin
				if (flow.idle_ticks != 16'hFFFF)
					flow.idle_ticks++;
				if (flow.idle_ticks > flow_regs.timeout_seconds) begin
					res.status           = ST_OK;
					res.flushed          = 1'b1;
					res.flush_reason     = REASON_TIMEOUT;
					res.delivered_length = flow.received_bytes + flow.final_header_bytes;
					res.highest_end      = flow.end_bytes;
					flow                 = '0;
					results_due.push_back(res);
				end
			end
		end else begin
			hdr_bytes    = beat.header_words * 4;
			offset_bytes = beat.offset_units * 8;
			payload      = 0;
			if (beat.version != IPV4_VERSION) begin
				status = ST_NOT_IPV4;
			end else if (hdr_bytes < MIN_HEADER_BYTES) begin
				status = ST_BAD_HDR_LEN;
			end else if (beat.total_length <= hdr_bytes) begin
				status = ST_NO_DATA;
			end else if (beat.src_addr != flow_regs.flow_source_addr ||
			             beat.dst_addr != flow_regs.flow_dest_addr) begin
				status = ST_ADDR_MISS;
			end else if ((!beat.more_fragments && offset_bytes == 0) || beat.dont_fragment) begin
				status = ST_NOT_FRAGMENT;
			end else begin
				payload = beat.total_length - hdr_bytes;
				if (beat.more_fragments && payload < flow_regs.min_fragment_bytes)
					status = ST_TOO_SHORT;
				else if (flow.received_bytes + payload > MAX_DATAGRAM_BYTES)
					status = ST_OVERRUN;
				else if (offset_bytes + payload > MAX_DATAGRAM_BYTES)
					status = ST_OVERRUN;
				else
					status = ST_OK;
			end
			res.status = status;
			if (status == ST_OK) begin
				frag_end = offset_bytes + payload;
				if (flow.end_bytes < frag_end)
					flow.end_bytes = frag_end[LEN_W-1:0];
				flow.received_bytes += payload[LEN_W-1:0];
				// the latest final fragment sets the header size
				if (!beat.more_fragments) begin
					flow.final_seen         = 1'b1;
					flow.final_header_bytes = hdr_bytes[HDR_B_W-1:0];
				end
				if (flow.final_seen && flow.end_bytes == flow.received_bytes) begin
					res.flushed          = 1'b1;
					res.flush_reason     = REASON_DONE;
					res.delivered_length = flow.received_bytes + flow.final_header_bytes;
					res.highest_end      = flow.end_bytes;
					flow                 = '0;
				end else begin
					flow.idle_ticks = '0;
					res.highest_end = flow.end_bytes;
				end
			end else begin
				res.highest_end = flow.end_bytes;
			end
			results_due.push_back(res);
		end
	endtask

	// signals only move at the rising edge, so the falling edge sees the beats of the next edge
	always @(negedge clk) begin : watch
		item_t   beat;
		result_t due;
		if (!arst_n) begin
			flow_regs.flow_source_addr   = '0;
			flow_regs.flow_dest_addr     = '0;
			flow_regs.min_fragment_bytes = MIN_FRAG_RESET;
			flow_regs.timeout_seconds    = TIMEOUT_RESET;
			flow                         = '0;
			results_due.delete();
		end else begin
			// result beat, always from an earlier input beat
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing due, status %0d",
						m_tdata[2:0]));
				end else begin
					due = results_due.pop_front();
					if (m_tdata[2:0] != due.status)
						report_mismatch($sformatf("status %0d, want %0d",
							m_tdata[2:0], due.status));
					if (m_tuser[0] != due.flushed)
						report_mismatch($sformatf("flushed %0b, want %0b",
							m_tuser[0], due.flushed));
					if (m_tuser[1] != due.flush_reason)
						report_mismatch($sformatf("flush_reason %0b, want %0b",
							m_tuser[1], due.flush_reason));
					if (m_tdata[19:3] != due.delivered_length)
						report_mismatch($sformatf("delivered_length %0d, want %0d",
							m_tdata[19:3], due.delivered_length));
					if (m_tdata[35:20] != due.highest_end)
						report_mismatch($sformatf("highest_end %0d, want %0d",
							m_tdata[35:20], due.highest_end));
					if (m_tdata[39:36] != '0)
						report_mismatch($sformatf("tdata padding %0h", m_tdata[39:36]));
				end
			end
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FLOW_SRC: flow_regs.flow_source_addr   = cfg_data;
					REG_FLOW_DST: flow_regs.flow_dest_addr     = cfg_data;
					REG_MIN_FRAG: flow_regs.min_fragment_bytes = cfg_data[LEN_W-1:0];
					REG_TIMEOUT:  flow_regs.timeout_seconds    = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			// input beat
			if (s_tvalid && s_tready) begin
				beat.kind           = s_tuser;
				beat.version        = s_tdata[3:0];
				beat.header_words   = s_tdata[7:4];
				beat.total_length   = s_tdata[23:8];
				beat.src_addr       = s_tdata[55:24];
				beat.dst_addr       = s_tdata[87:56];
				beat.more_fragments = s_tdata[88];
				beat.dont_fragment  = s_tdata[89];
				beat.offset_units   = s_tdata[102:90];
				account_item(beat);
			end
		end
		due_count = results_due.size();
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench
	import ifa_pkg::*;
();

	localparam int unsigned MAX_DATAGRAM = 65535;
	localparam int unsigned STALL_MAX    = 13;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned RANDOM_ITEMS = 1900;
	localparam int unsigned PHASE_ITEMS  = 160;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// [3:0] version, [7:4] header_words, [23:8] total_length, [55:24] src_addr,
	// [87:56] dst_addr, [88] more_fragments, [89] dont_fragment,
	// [102:90] offset_units, [103] zero
	logic [S_TDATA_W-1:0]  s_tdata;
	// [0] kind
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [2:0] status, [19:3] delivered_length, [35:20] highest_end, [39:36] zero
	logic [M_TDATA_W-1:0]  m_tdata;
	// [0] flushed, [1] flush_reason
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned errors;
	int unsigned pending;
	int unsigned quiet_cycles = 0;
	int unsigned sent         = 0;
	// 0 never idle, 1 a random idle gap up to STALL_MAX per beat, 2 mostly back to back
	int unsigned send_mode    = 1;
	int unsigned sink_mode    = 1;

	// flow identity and limits as last written
	logic [ADDR_W-1:0] flow_src;
	logic [ADDR_W-1:0] flow_dst;
	logic [LEN_W-1:0]  min_frag;
	logic [LEN_W-1:0]  timeout_now;

	ipv4_fragment_accounting_core #(
		.MAX_DATAGRAM_BYTES(MAX_DATAGRAM)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	ifa_flow_checker #(
		.MAX_DATAGRAM_BYTES(MAX_DATAGRAM)
	) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// end the run when no channel moves for too long
	always @(negedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int unsigned draw_wait(input int unsigned mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, STALL_MAX);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, STALL_MAX) : 0;
		endcase
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.kind           = 1'b0;
		it.version        = 4'($urandom_range(0, 15));
		it.header_words   = 4'($urandom_range(0, 15));
		it.total_length   = 16'($urandom_range(0, 65535));
		it.src_addr       = $urandom;
		it.dst_addr       = $urandom;
		it.more_fragments = 1'($urandom_range(0, 1));
		it.dont_fragment  = 1'($urandom_range(0, 1));
		it.offset_units   = 13'($urandom_range(0, 8191));
		return it;
	endfunction

	// ticks carry random junk in the header fields
	function automatic item_t tick_item();
		item_t it;
		it      = random_item();
		it.kind = 1'b1;
		return it;
	endfunction

	// well-formed header of this flow
	function automatic item_t frag(input logic [3:0] hwords, input logic [15:0] total,
	                               input logic [12:0] off_units, input logic mf,
	                               input logic df);
		item_t it;
		it.kind           = 1'b0;
		it.version        = IPV4_VERSION;
		it.header_words   = hwords;
		it.total_length   = total;
		it.src_addr       = flow_src;
		it.dst_addr       = flow_dst;
		it.more_fragments = mf;
		it.dont_fragment  = df;
		it.offset_units   = off_units;
		return it;
	endfunction

	// one input beat, with a random gap in front
	task automatic send_item(input item_t it);
		int unsigned gap;
		gap = draw_wait(send_mode);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tdata  <= {1'b0, it.offset_units, it.dont_fragment, it.more_fragments,
		             it.dst_addr, it.src_addr, it.total_length, it.header_words,
		             it.version};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		sent++;
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n) send_item(tick_item());
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
	                              input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits of the 16-bit registers are junk and must be dropped
	task automatic set_flow(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
	                        input logic [LEN_W-1:0] minf, input logic [LEN_W-1:0] tmo);
		flow_src    = src;
		flow_dst    = dst;
		min_frag    = minf;
		timeout_now = tmo;
		write_register(REG_FLOW_SRC, src);
		write_register(REG_FLOW_DST, dst);
		write_register(REG_MIN_FRAG, {16'($urandom), minf});
		write_register(REG_TIMEOUT, {16'($urandom), tmo});
	endtask

	// stop sending and let every result and any silent tick work through
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one datagram cut into fragments, sent shuffled, sometimes with a hole or a repeat
	task automatic send_datagram();
		int unsigned frags;
		int unsigned need;
		int unsigned hwords;
		int unsigned bytes;
		int unsigned swap_at;
		int unsigned tmp;
		int unsigned k;
		int unsigned drop_at;
		int unsigned dup_at;
		int unsigned last_bytes;
		int unsigned frag_units[6];
		int unsigned frag_start[6];
		int unsigned frag_order[6];
		logic        drop_one;
		logic        dup_one;
		logic        mf;
		item_t       it;
		frags      = $urandom_range(2, 6);
		need       = (min_frag <= 8192) ? (min_frag + 7) / 8 : 0;
		last_bytes = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 4000)
		                                          : $urandom_range(1, 64);
		for (int i = 0; i < frags; i++) begin
			frag_units[i] = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 1024)
			                                             : $urandom_range(1, 8);
			if (frag_units[i] < need)
				frag_units[i] = need;
			frag_start[i] = (i == 0) ? 0 : frag_start[i-1] + frag_units[i-1];
			frag_order[i] = i;
		end
		for (int i = frags - 1; i > 0; i--) begin
			swap_at             = $urandom_range(0, i);
			tmp                 = frag_order[i];
			frag_order[i]       = frag_order[swap_at];
			frag_order[swap_at] = tmp;
		end
		drop_one = ($urandom_range(0, 9) == 0);
		dup_one  = ($urandom_range(0, 9) == 0);
		drop_at  = $urandom_range(0, frags - 1);
		dup_at   = $urandom_range(0, frags - 1);
		for (int i = 0; i < frags; i++) begin
			k      = frag_order[i];
			mf     = (k != frags - 1);
			hwords = $urandom_range(5, 15);
			bytes  = mf ? frag_units[k] * 8 : last_bytes;
			it     = frag(4'(hwords), 16'(hwords * 4 + bytes), 13'(frag_start[k]), mf,
			              $urandom_range(0, 19) == 0);
			if (!(drop_one && k == drop_at))
				send_item(it);
			if (dup_one && k == dup_at)
				send_item(it);
			if ($urandom_range(0, 7) == 0)
				send_ticks($urandom_range(1, 2));
		end
		// age out whatever is left of a broken datagram, when the timeout is short enough
		if (drop_one || dup_one)
			send_ticks((timeout_now < 40) ? timeout_now + 1 : 3);
	endtask

	// result side: a random stall before each result beat
	initial begin : result_sink
		int unsigned stall;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_wait(sink_mode);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
		end
	end

	initial begin : stimulus
		int unsigned phase;
		int unsigned phase_end;
		int unsigned pick;
		item_t       it;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FLOW_SRC;
		cfg_data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every rejection, timeout, reassembly and the length extremes
		set_flow(32'hC0A8_0001, 32'h0A00_0002, 16'd8, 16'd2);
		it = frag(5, 40, 0, 1'b1, 1'b0);
		it.version = 4'd0;
		send_item(it);
		send_item(frag(4, 40, 0, 1'b1, 1'b0));
		send_item(frag(5, 20, 0, 1'b1, 1'b0));
		it = frag(5, 40, 0, 1'b1, 1'b0);
		it.src_addr[0] = ~it.src_addr[0];
		send_item(it);
		it = frag(5, 40, 0, 1'b1, 1'b0);
		it.dst_addr[31] = ~it.dst_addr[31];
		send_item(it);
		send_item(frag(5, 40, 0, 1'b0, 1'b0));
		send_item(frag(5, 40, 1, 1'b1, 1'b1));
		send_item(frag(5, 24, 0, 1'b1, 1'b0));
		send_item(frag(5, 36, 8191, 1'b1, 1'b0));
		// partial flow that times out without a final fragment
		send_item(frag(5, 36, 0, 1'b1, 1'b0));
		send_ticks(3);
		// tick on an empty flow gives nothing
		send_ticks(1);
		// two fragments that complete the datagram
		send_item(frag(15, 84, 0, 1'b1, 1'b0));
		send_item(frag(5, 28, 3, 1'b0, 1'b0));
		// final fragment twice, the later header size counts
		send_item(frag(6, 32, 2, 1'b0, 1'b0));
		send_item(frag(7, 36, 2, 1'b0, 1'b0));
		send_item(frag(5, 28, 0, 1'b1, 1'b0));
		// near full datagram, received-count overrun, then a 17-bit delivered length
		send_item(frag(15, 65535, 0, 1'b1, 1'b0));
		send_item(frag(15, 67, 8191, 1'b0, 1'b0));
		send_item(frag(5, 28, 0, 1'b1, 1'b0));
		send_item(frag(5, 120, 0, 1'b1, 1'b0));
		send_ticks(3);
		drain();

		// random phases, each with its own setting and idle pattern
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase)
				0: set_flow(32'h0000_0000, 32'hFFFF_FFFF, 16'd0, 16'd0);
				1: set_flow(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
				2: set_flow($urandom, $urandom, 16'd8, 16'd30);
				default: begin
					pick = $urandom_range(0, 4);
					set_flow($urandom, $urandom,
						(pick == 0) ? 16'($urandom) :
						(pick == 1) ? 16'd0 : 16'($urandom_range(1, 64)),
						($urandom_range(0, 5) == 0) ? 16'($urandom_range(20, 40)) :
						16'($urandom_range(0, 5)));
				end
			endcase
			send_mode = (phase == 3) ? 0 : $urandom_range(0, 2);
			sink_mode = (phase == 4) ? 0 : $urandom_range(0, 2);
			phase_end = sent + PHASE_ITEMS;
			while (sent < phase_end) begin
				pick = $urandom_range(0, 9);
				if (pick < 8) begin
					send_datagram();
				end else if (pick == 8) begin
					it = random_item();
					if ($urandom_range(0, 1)) begin
						it.src_addr = flow_src;
						it.dst_addr = flow_dst;
					end
					if ($urandom_range(0, 1))
						it.version = IPV4_VERSION;
					send_item(it);
				end else begin
					send_ticks($urandom_range(1, 6));
				end
			end
			drain();
			phase++;
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
